### sv/u8sld_pkg.sv
package u8sld_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int NUM_SCRIPTS = 6;
   localparam int CP_WIDTH = 21;

   // script counter slots
   localparam int SCR_HANGUL = 0;
   localparam int SCR_KANA = 1;
   localparam int SCR_CJK = 2;
   localparam int SCR_ARABIC = 3;
   localparam int SCR_CYRILLIC = 4;
   localparam int SCR_LATIN = 5;

   typedef enum logic [2:0] {
      LANG_NONE = 3'd0,
      LANG_KO = 3'd1,
      LANG_JA = 3'd2,
      LANG_ZH = 3'd3,
      LANG_AR = 3'd4,
      LANG_UK = 3'd5,
      LANG_RU = 3'd6,
      LANG_EN = 3'd7
   } lang_type;

   typedef struct packed {
      logic [NUM_SCRIPTS-1:0] hit;
      logic ukr;
   } class_type;

   typedef struct packed {
      logic fire;
      logic last;
      logic [7:0] text_byte;
   } step_type;

   function automatic logic ukrainian_letter(input logic [CP_WIDTH-1:0] c);
      return c == 21'h406 || c == 21'h456 || c == 21'h407 || c == 21'h457 ||
             c == 21'h404 || c == 21'h454 || c == 21'h490 || c == 21'h491;
   endfunction

   function automatic class_type classify(input logic [CP_WIDTH-1:0] c);
      class_type r;
      r = '0;
      if (c >= 21'hAC00 && c <= 21'hD7AF) begin
         r.hit[SCR_HANGUL] = 1'b1;
      end else if (c >= 21'h3040 && c <= 21'h30FF) begin
         r.hit[SCR_KANA] = 1'b1;
      end else if (c >= 21'h4E00 && c <= 21'h9FFF) begin
         r.hit[SCR_CJK] = 1'b1;
      end else if (c >= 21'h0600 && c <= 21'h06FF) begin
         r.hit[SCR_ARABIC] = 1'b1;
      end else if ((c >= 21'h410 && c <= 21'h44F) || c == 21'h401 || c == 21'h451 ||
                   ukrainian_letter(c)) begin
         r.hit[SCR_CYRILLIC] = 1'b1;
         r.ukr = ukrainian_letter(c);
      end else if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
                   (c >= 21'hC0 && c <= 21'hFF)) begin
         r.hit[SCR_LATIN] = 1'b1;
      end
      return r;
   endfunction

endpackage

### sv/u8sld_count.sv
module u8sld_count #(
   parameter int COUNT_WIDTH = u8sld_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  u8sld_pkg::step_type step,
   output logic [u8sld_pkg::NUM_SCRIPTS-1:0][COUNT_WIDTH-1:0] counts_next,
   output logic ukr_next
);

   localparam int CPW = u8sld_pkg::CP_WIDTH;
   localparam int NS = u8sld_pkg::NUM_SCRIPTS;

   logic [CPW-1:0] partial_ff, partial_in;
   logic [1:0] cont_ff, cont_in;
   logic [NS-1:0][COUNT_WIDTH-1:0] counts_ff;
   logic ukr_ff;

   logic slot_a_v, slot_b_v, lead;
   logic [CPW-1:0] slot_a_cp, slot_b_cp;
   u8sld_pkg::class_type cls_a, cls_b;
   logic [COUNT_WIDTH:0] sum [NS];

   // decode: slot a takes a finished or broken code point, slot b a single
   // byte code point or the truncated tail on the last byte
   always_comb begin
      slot_a_v = 1'b0;
      slot_b_v = 1'b0;
      slot_a_cp = partial_ff;
      slot_b_cp = {13'b0, step.text_byte};
      partial_in = partial_ff;
      cont_in = cont_ff;
      lead = 1'b0;
      if (cont_ff != 2'd0) begin
         if (step.text_byte[7:6] == 2'b10) begin
            partial_in = {partial_ff[CPW-7:0], step.text_byte[5:0]};
            cont_in = cont_ff - 2'd1;
            if (cont_in == 2'd0) begin
               slot_a_v = 1'b1;
               slot_a_cp = partial_in;
            end
         end else begin
            cont_in = 2'd0;
            slot_a_v = 1'b1;
            lead = 1'b1;
         end
      end else begin
         lead = 1'b1;
      end
      if (lead) begin
         case (step.text_byte) inside
            8'b110?????: begin
               partial_in = {16'b0, step.text_byte[4:0]};
               cont_in = 2'd1;
            end
            8'b1110????: begin
               partial_in = {17'b0, step.text_byte[3:0]};
               cont_in = 2'd2;
            end
            8'b11110???: begin
               partial_in = {18'b0, step.text_byte[2:0]};
               cont_in = 2'd3;
            end
            default: begin
               slot_b_v = 1'b1;
            end
         endcase
      end
      if (step.last && cont_in != 2'd0) begin
         slot_b_v = 1'b1;
         slot_b_cp = partial_in;
      end
   end

   always_comb begin
      cls_a = u8sld_pkg::classify(slot_a_cp);
      cls_b = u8sld_pkg::classify(slot_b_cp);
      for (int i = 0; i < NS; i++) begin
         sum[i] = {1'b0, counts_ff[i]} +
                  (COUNT_WIDTH+1)'(cls_a.hit[i] & slot_a_v) +
                  (COUNT_WIDTH+1)'(cls_b.hit[i] & slot_b_v);
         counts_next[i] = sum[i][COUNT_WIDTH] ? '1 : sum[i][COUNT_WIDTH-1:0];
      end
      ukr_next = ukr_ff | (cls_a.ukr & slot_a_v) | (cls_b.ukr & slot_b_v);
   end

   // the last byte of a text clears everything for the next text
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         cont_ff <= 2'd0;
         counts_ff <= '0;
         ukr_ff <= 1'b0;
      end else if (step.fire) begin
         if (step.last) begin
            partial_ff <= '0;
            cont_ff <= 2'd0;
            counts_ff <= '0;
            ukr_ff <= 1'b0;
         end else begin
            partial_ff <= partial_in;
            cont_ff <= cont_in;
            counts_ff <= counts_next;
            ukr_ff <= ukr_next;
         end
      end
   end

endmodule

### sv/u8sld_lang.sv
module u8sld_lang #(
   parameter int COUNT_WIDTH = u8sld_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic [u8sld_pkg::NUM_SCRIPTS-1:0][COUNT_WIDTH-1:0] counts,
   input  logic ukr,
   output u8sld_pkg::lang_type language
);

   localparam int SW = COUNT_WIDTH + 5;

   logic [SW-1:0] h, k, z, a, cy, la, total;
   logic [SW-1:0] h5, k20, z10, a10, total3;

   always_comb begin
      h = SW'(counts[u8sld_pkg::SCR_HANGUL]);
      k = SW'(counts[u8sld_pkg::SCR_KANA]);
      z = SW'(counts[u8sld_pkg::SCR_CJK]);
      a = SW'(counts[u8sld_pkg::SCR_ARABIC]);
      cy = SW'(counts[u8sld_pkg::SCR_CYRILLIC]);
      la = SW'(counts[u8sld_pkg::SCR_LATIN]);
      total = h + k + z + a + cy + la;
      // constant multiples as shift and add
      h5 = (h << 2) + h;
      k20 = (k << 4) + (k << 2);
      z10 = (z << 3) + (z << 1);
      a10 = (a << 3) + (a << 1);
      total3 = (total << 1) + total;
      if (total == '0) begin
         language = u8sld_pkg::LANG_NONE;
      end else if (h5 > total) begin
         language = u8sld_pkg::LANG_KO;
      end else if (k20 > total3) begin
         language = u8sld_pkg::LANG_JA;
      end else if (z10 > total3) begin
         language = u8sld_pkg::LANG_ZH;
      end else if (a10 > total3) begin
         language = u8sld_pkg::LANG_AR;
      end else if (cy >= la && cy != '0) begin
         language = ukr ? u8sld_pkg::LANG_UK : u8sld_pkg::LANG_RU;
      end else if (la != '0) begin
         language = u8sld_pkg::LANG_EN;
      end else begin
         language = u8sld_pkg::LANG_NONE;
      end
   end

endmodule

### sv/utf8_script_language_detector_top.sv
// rsp_tvalid rises after a last byte passes the input, snapshot and output registers
// throughput: one byte per cycle; bytes that are not last never wait on the output side
// last bytes may stall; count stage decode and counter update set the rate
// reset: synchronous, active high; clears all valid flags, decoder state and counters
module utf8_script_language_detector_top #(
   parameter int COUNT_WIDTH = u8sld_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,    // [7:0] text_byte
   input  logic req_tlast,          // last_byte
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata     // [2:0] language, [7:3] zero
);

   localparam int NS = u8sld_pkg::NUM_SCRIPTS;

   // stage 1: input register
   logic s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic s1_last_ff;
   logic s1_fire;

   // stage 2: snapshot of the final counts of one text
   logic s2_valid_ff, s2_valid_in;
   logic [NS-1:0][COUNT_WIDTH-1:0] s2_counts_ff;
   logic s2_ukr_ff;
   logic s2_ready, s2_go;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   u8sld_pkg::lang_type rsp_lang_ff;

   u8sld_pkg::step_type step;
   logic [NS-1:0][COUNT_WIDTH-1:0] counts_next;
   logic ukr_next;
   u8sld_pkg::lang_type lang;

   // handshake: only a last byte needs room in the snapshot stage
   assign s2_go = !rsp_valid_ff || rsp_tready;
   assign s2_ready = !s2_valid_ff || s2_go;
   assign s1_fire = s1_valid_ff && (!s1_last_ff || s2_ready);
   assign req_tready = !s1_valid_ff || s1_fire;

   assign step = '{fire: s1_fire, last: s1_last_ff, text_byte: s1_byte_ff};

   // utf-8 decode, classification and saturating counters
   u8sld_count #(.COUNT_WIDTH(COUNT_WIDTH)) u_count (
      .clock(clock),
      .reset(reset),
      .step(step),
      .counts_next(counts_next),
      .ukr_next(ukr_next)
   );

   // ratio rules on the snapshot
   u8sld_lang #(.COUNT_WIDTH(COUNT_WIDTH)) u_lang (
      .counts(s2_counts_ff),
      .ukr(s2_ukr_ff),
      .language(lang)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_fire && s1_last_ff) begin
         s2_valid_in = 1'b1;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_valid_ff && s2_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_fire && s1_last_ff) begin
         s2_counts_ff <= counts_next;
         s2_ukr_ff <= ukr_next;
      end
      if (s2_valid_ff && s2_go) begin
         rsp_lang_ff <= lang;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, rsp_lang_ff};

endmodule
